/* src/lmrs_pkg.sv */
// shared constants and types for the led matrix row scanner
`timescale 1ns / 1ps

package lmrs_pkg;

  // frame geometry
  localparam int ROWS = 8;
  localparam int BANKS = 2;
  localparam int ROW_W = $clog2(ROWS);
  localparam int BANK_W = $clog2(BANKS);
  localparam int STORE_DEPTH = BANKS * ROWS;
  localparam int STORE_W = $clog2(STORE_DEPTH);

  // burst layout: inverted column byte then row mask, msb first
  localparam int BYTE_W = 8;
  localparam int BURST_BITS = 2 * BYTE_W;
  localparam int BIT_CNT_W = $clog2(BURST_BITS);
  localparam int SCAN_ROW_W = 3;

  // burst queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // operation codes
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_CHOOSE = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  // one pending burst
  typedef struct packed {
    logic [BURST_BITS-1:0] word;
    logic [SCAN_ROW_W-1:0] row;
  } burst_t;

  // serialiser states
  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } back_state_t;

endpackage

/* src/lmrs_front.sv */
// front end: takes operations, keeps frame banks and row scan state, issues bursts
`timescale 1ns / 1ps

module lmrs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           operation,
  input  logic                 bank,
  input  logic [2:0]           row_index,
  input  logic [7:0]           row_data,
  output logic                 burst_push,
  output lmrs_pkg::burst_t     burst
);

  logic [lmrs_pkg::BYTE_W-1:0]  frame [lmrs_pkg::STORE_DEPTH];
  logic [lmrs_pkg::ROW_W-1:0]   row_counter;
  logic [lmrs_pkg::ROW_W-1:0]   row_counter_next;
  logic [lmrs_pkg::BANK_W-1:0]  shown_bank;
  logic [lmrs_pkg::BANK_W-1:0]  chosen_bank;
  logic [lmrs_pkg::STORE_W-1:0] wr_idx;
  logic [lmrs_pkg::STORE_W-1:0] rd_idx;
  logic                         wr_en;
  logic                         choose_en;
  logic                         tick_en;
  logic                         bank_ok;
  logic [lmrs_pkg::BYTE_W-1:0]  cols;
  logic [lmrs_pkg::BYTE_W-1:0]  mask;

  // decode the accepted word
  assign bank_ok = (32'(bank) < lmrs_pkg::BANKS);
  always_comb begin
    wr_en = 1'b0;
    choose_en = 1'b0;
    tick_en = 1'b0;
    if (accept && bank_ok) begin
      unique case (lmrs_pkg::op_t'(operation))
        lmrs_pkg::OP_WRITE:  wr_en = (32'(row_index) < lmrs_pkg::ROWS);
        lmrs_pkg::OP_CHOOSE: choose_en = 1'b1;
        lmrs_pkg::OP_TICK:   tick_en = 1'b1;
        default: ;
      endcase
    end
  end

  // store addressing
  assign wr_idx = lmrs_pkg::STORE_W'(32'(bank) * lmrs_pkg::ROWS + 32'(row_index));
  assign rd_idx = lmrs_pkg::STORE_W'(32'(shown_bank) * lmrs_pkg::ROWS + 32'(row_counter));

  // burst contents: inverted columns and one-hot row mask
  assign cols = ~frame[rd_idx];
  assign mask = (32'(row_counter) < lmrs_pkg::BYTE_W) ?
                (lmrs_pkg::BYTE_W'(1) << row_counter) : '0;
  assign burst_push = tick_en;
  assign burst.word = {cols, mask};
  assign burst.row = lmrs_pkg::SCAN_ROW_W'(row_counter);

  // row advance with wrap
  assign row_counter_next = (32'(row_counter) == lmrs_pkg::ROWS - 1) ?
                            '0 : row_counter + 1'b1;

  // frame banks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lmrs_pkg::STORE_DEPTH; i++) begin
        frame[i] <= '0;
      end
    end else if (wr_en) begin
      frame[wr_idx] <= row_data;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      shown_bank <= '0;
      chosen_bank <= '0;
    end else begin
      if (choose_en) begin
        chosen_bank <= lmrs_pkg::BANK_W'(bank);
      end
      if (tick_en) begin
        row_counter <= row_counter_next;
        if (row_counter_next == '0) begin
          shown_bank <= chosen_bank;
        end
      end
    end
  end

  // a tick on the last row wraps to row 0
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    tick_en && (32'(row_counter) == lmrs_pkg::ROWS - 1) |=> row_counter == '0)
    else $error("row counter did not wrap");

  // the shown bank moves only on a wrapping tick
  a_bank_hold: assert property (@(posedge clk) disable iff (rst)
    !(tick_en && row_counter_next == '0) |=> $stable(shown_bank))
    else $error("shown bank changed mid frame");

endmodule

/* src/lmrs_queue.sv */
// short burst queue between the front and back ends
`timescale 1ns / 1ps

module lmrs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  lmrs_pkg::burst_t wr_data,
  output logic             full,
  input  logic             rd,
  output lmrs_pkg::burst_t rd_data,
  output logic             empty
);

  lmrs_pkg::burst_t            slots [lmrs_pkg::QDEPTH];
  logic [lmrs_pkg::QPTR_W-1:0] wr_ptr;
  logic [lmrs_pkg::QPTR_W-1:0] rd_ptr;
  logic [lmrs_pkg::QCNT_W-1:0] count;

  assign full = (32'(count) == lmrs_pkg::QDEPTH);
  assign empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (32'(wr_ptr) == lmrs_pkg::QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (32'(rd_ptr) == lmrs_pkg::QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> !full)
    else $error("burst queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> !empty)
    else $error("burst queue underflow");

endmodule

/* src/lmrs_back.sv */
// back end: shifts each burst out one bit per word with a result register
`timescale 1ns / 1ps

module lmrs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  lmrs_pkg::burst_t q_data,
  output logic             q_pop,
  input  logic             out_take,
  output logic             out_valid,
  output logic             serial_bit,
  output logic             latch_after,
  output logic [2:0]       scanned_row
);

  lmrs_pkg::back_state_t            state;
  lmrs_pkg::back_state_t            state_next;
  logic [lmrs_pkg::BURST_BITS-1:0]  shifter;
  logic [lmrs_pkg::SCAN_ROW_W-1:0]  row;
  logic [lmrs_pkg::BIT_CNT_W-1:0]   bit_cnt;
  logic                             out_free;
  logic                             load_out;
  logic                             last_bit;

  assign out_free = !out_valid || out_take;
  assign last_bit = (32'(bit_cnt) == lmrs_pkg::BURST_BITS - 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lmrs_pkg::ST_IDLE:  if (!q_empty) state_next = lmrs_pkg::ST_SHIFT;
      lmrs_pkg::ST_SHIFT: if (out_free && last_bit) state_next = lmrs_pkg::ST_IDLE;
      default:            state_next = lmrs_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop = 1'b0;
    load_out = 1'b0;
    unique case (state)
      lmrs_pkg::ST_IDLE:  q_pop = !q_empty;
      lmrs_pkg::ST_SHIFT: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shift register and bit count
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (q_pop) begin
      bit_cnt <= '0;
    end else if (load_out) begin
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      shifter <= q_data.word;
      row <= q_data.row;
    end else if (load_out) begin
      shifter <= {shifter[lmrs_pkg::BURST_BITS-2:0], 1'b0};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      serial_bit <= shifter[lmrs_pkg::BURST_BITS-1];
      latch_after <= last_bit;
      scanned_row <= row;
    end
  end

  // the sixteenth bit leaves flagged as the latch
  a_latch_flag: assert property (@(posedge clk) disable iff (rst)
    load_out && last_bit |=> out_valid && latch_after)
    else $error("latch flag missing on last bit");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_take |=> out_valid && $stable(serial_bit) && $stable(scanned_row))
    else $error("pending result overwritten");

endmodule

/* src/led_matrix_row_scanner_serial.sv */
// top level of the led matrix row scanner with serial shift register output
`timescale 1ns / 1ps

// Row-scanned 8x8 LED matrix driver with two frame banks. Operation 0 writes
// a row byte into a bank, operation 1 picks the bank shown from the next
// frame start, operation 2 (refresh tick) emits sixteen words: the inverted
// column byte of the current row then the one-hot row mask, msb first, the
// last word flagged with latch_after. A tick is taken into a two-entry
// burst queue; the serialiser loads each burst from the queue and then gives
// one bit per cycle while its output words are popped, sixteen bits per burst,
// so further ticks can be queued while a burst is still shifting. Banks are
// cleared by reset.

module led_matrix_row_scanner_serial (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] operation,
  input  logic       bank,
  input  logic [2:0] row_index,
  input  logic [7:0] row_data,
  output logic       empty,
  input  logic       pop,
  output logic       serial_bit,
  output logic       latch_after,
  output logic [2:0] scanned_row
);

  logic             accept;
  logic             burst_push;
  lmrs_pkg::burst_t burst;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  lmrs_pkg::burst_t q_data;
  logic             out_valid;

  assign full = q_full;
  assign accept = push && !q_full;
  assign empty = !out_valid;

  // operation decode and frame state
  lmrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (operation),
    .bank       (bank),
    .row_index  (row_index),
    .row_data   (row_data),
    .burst_push (burst_push),
    .burst      (burst)
  );

  // pending bursts
  lmrs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (burst_push),
    .wr_data (burst),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // serialiser
  lmrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_take    (pop && out_valid),
    .out_valid   (out_valid),
    .serial_bit  (serial_bit),
    .latch_after (latch_after),
    .scanned_row (scanned_row)
  );

endmodule
